// File: hdl/tre_pkg.sv
// Shared types and constants for the tile rectangle enumerator.
// No dependencies; every other file in hdl/ imports this package.
package tre_pkg;

    localparam int MAX_COLUMNS_DEF = 8;
    localparam int MAX_ROWS_DEF    = 8;
    localparam int SIZE_BITS_DEF   = 14;

    localparam int SLOT_MAX    = 8;     // slots held in the size registers
    localparam int IDX_W       = 3;     // bits of a column or row index
    localparam int CNT_W       = 4;     // bits of a column or row count
    localparam int CFG_DATA_W  = 56;
    localparam int CFG_INDEX_W = 3;
    localparam int PACK_W      = 64;    // four sizes of up to 16 bits
    localparam int COORD_W     = 16;
    localparam int POS_W       = 17;    // x + width - 1 without wrap
    localparam int TILE_W      = 6;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NUM_COLUMNS        = 3'd0,
        REG_NUM_ROWS           = 3'd1,
        REG_COLUMN_WIDTHS_LOW  = 3'd2,
        REG_COLUMN_WIDTHS_HIGH = 3'd3,
        REG_ROW_HEIGHTS_LOW    = 3'd4,
        REG_ROW_HEIGHTS_HIGH   = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_SEARCH,
        FS_PUSH
    } front_state_t;

    // One classified rectangle handed from the front end to the tile walker.
    typedef struct packed {
        logic [IDX_W-1:0] first_column;
        logic [IDX_W-1:0] end_column;
        logic [IDX_W-1:0] first_row;
        logic [IDX_W-1:0] end_row;
        logic [CNT_W-1:0] num_columns;
        logic             err;
    } job_t;

endpackage

// File: hdl/tre_cfg.sv
// Configuration register file: tile counts and packed column/row sizes.
// Depends on tre_pkg.
module tre_cfg #(
    parameter int MAX_COLUMNS = tre_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tre_pkg::MAX_ROWS_DEF,
    parameter int SIZE_BITS   = tre_pkg::SIZE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tre_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tre_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [SIZE_BITS-1:0]             col_size [tre_pkg::SLOT_MAX],
    output logic [SIZE_BITS-1:0]             row_size [tre_pkg::SLOT_MAX],
    output logic [tre_pkg::CNT_W-1:0]        ncols,
    output logic [tre_pkg::CNT_W-1:0]        nrows
);
    import tre_pkg::*;

    logic [CNT_W-1:0]      num_columns_reg;
    logic [CNT_W-1:0]      num_rows_reg;
    logic [CFG_DATA_W-1:0] col_lo_reg;
    logic [CFG_DATA_W-1:0] col_hi_reg;
    logic [CFG_DATA_W-1:0] row_lo_reg;
    logic [CFG_DATA_W-1:0] row_hi_reg;
    logic [PACK_W-1:0]     col_lo_wide;
    logic [PACK_W-1:0]     col_hi_wide;
    logic [PACK_W-1:0]     row_lo_wide;
    logic [PACK_W-1:0]     row_hi_wide;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_columns_reg <= CNT_W'(1);
            num_rows_reg    <= CNT_W'(1);
            col_lo_reg      <= '0;
            col_hi_reg      <= '0;
            row_lo_reg      <= '0;
            row_hi_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                REG_NUM_COLUMNS:        num_columns_reg <= cfg_data[CNT_W-1:0];
                REG_NUM_ROWS:           num_rows_reg    <= cfg_data[CNT_W-1:0];
                REG_COLUMN_WIDTHS_LOW:  col_lo_reg      <= cfg_data;
                REG_COLUMN_WIDTHS_HIGH: col_hi_reg      <= cfg_data;
                REG_ROW_HEIGHTS_LOW:    row_lo_reg      <= cfg_data;
                REG_ROW_HEIGHTS_HIGH:   row_hi_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Zero-extend so that a 16-bit size in the top slot reads zeros above bit 55.
    assign col_lo_wide = PACK_W'(col_lo_reg);
    assign col_hi_wide = PACK_W'(col_hi_reg);
    assign row_lo_wide = PACK_W'(row_lo_reg);
    assign row_hi_wide = PACK_W'(row_hi_reg);

    always_comb
    begin
        for (int k = 0; k < SLOT_MAX / 2; k++)
        begin
            col_size[k]                = col_lo_wide[SIZE_BITS*k +: SIZE_BITS];
            col_size[k + SLOT_MAX / 2] = col_hi_wide[SIZE_BITS*k +: SIZE_BITS];
            row_size[k]                = row_lo_wide[SIZE_BITS*k +: SIZE_BITS];
            row_size[k + SLOT_MAX / 2] = row_hi_wide[SIZE_BITS*k +: SIZE_BITS];
        end
    end

    // Counts above the supported maximum saturate.
    assign ncols = (num_columns_reg > CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS)
                                                           : num_columns_reg;
    assign nrows = (num_rows_reg > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : num_rows_reg;

endmodule

// File: hdl/tre_front.sv
// Front end: accepts a rectangle and walks the slot sizes one per cycle,
// locating the first and last column and row. Depends on tre_pkg.
module tre_front #(
    parameter int MAX_COLUMNS = tre_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tre_pkg::MAX_ROWS_DEF,
    parameter int SIZE_BITS   = tre_pkg::SIZE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tre_pkg::IN_DATA_W-1:0]  s_tdata,    // rect_x, rect_y, rect_width, rect_height
    input  logic [SIZE_BITS-1:0]           col_size [tre_pkg::SLOT_MAX],
    input  logic [SIZE_BITS-1:0]           row_size [tre_pkg::SLOT_MAX],
    input  logic [tre_pkg::CNT_W-1:0]      ncols,
    input  logic [tre_pkg::CNT_W-1:0]      nrows,
    output logic                           push,
    output tre_pkg::job_t                  push_job,
    input  logic                           queue_full
);
    import tre_pkg::*;

    localparam int SLOTS = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int ACC_W = (SIZE_BITS + 3 > POS_W) ? SIZE_BITS + 3 : POS_W;

    front_state_t     state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             accept;
    logic             searching;
    logic             idx_last;

    logic [POS_W-1:0] x0_reg, x0_next, x1_reg, x1_next;
    logic [POS_W-1:0] y0_reg, y0_next, y1_reg, y1_next;
    logic             empty_reg, empty_next;
    logic [ACC_W-1:0] col_start_reg, col_start_next;
    logic [ACC_W-1:0] row_start_reg, row_start_next;
    logic [3:0]       found_reg, found_next;   // first col, end col, first row, end row
    logic [IDX_W-1:0] c0_reg, c0_next, c1_reg, c1_next;
    logic [IDX_W-1:0] r0_reg, r0_next, r1_reg, r1_next;

    logic [COORD_W-1:0] in_x, in_y, in_w, in_h;
    logic [ACC_W-1:0]   cur_col_size, cur_row_size;
    logic               col_live, row_live;

    function automatic logic in_slot(input logic [POS_W-1:0] pos,
                                     input logic [ACC_W-1:0] start,
                                     input logic [ACC_W-1:0] size);
        logic [ACC_W-1:0] p;
        begin
            p = ACC_W'(pos);
            in_slot = (p >= start) && (p < start + size);
        end
    endfunction

    assign in_x = s_tdata[0*COORD_W +: COORD_W];
    assign in_y = s_tdata[1*COORD_W +: COORD_W];
    assign in_w = s_tdata[2*COORD_W +: COORD_W];
    assign in_h = s_tdata[3*COORD_W +: COORD_W];

    assign idx_last = (idx_reg == IDX_W'(SLOTS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE:   if (s_tvalid) state_next = FS_SEARCH;
            FS_SEARCH: if (idx_last) state_next = FS_PUSH;
            FS_PUSH:   if (!queue_full) state_next = FS_IDLE;
            default:   state_next = FS_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready  = 1'b0;
        searching = 1'b0;
        push      = 1'b0;
        case (state_reg)
            FS_IDLE:   s_tready  = 1'b1;
            FS_SEARCH: searching = 1'b1;
            FS_PUSH:   push      = !queue_full;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    assign cur_col_size = ACC_W'(col_size[idx_reg]);
    assign cur_row_size = ACC_W'(row_size[idx_reg]);
    assign col_live     = (CNT_W'(idx_reg) < ncols);
    assign row_live     = (CNT_W'(idx_reg) < nrows);

    always_comb
    begin
        idx_next       = idx_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        y0_next        = y0_reg;
        y1_next        = y1_reg;
        empty_next     = empty_reg;
        col_start_next = col_start_reg;
        row_start_next = row_start_reg;
        found_next     = found_reg;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        if (accept)
        begin
            x0_next        = POS_W'(in_x);
            x1_next        = POS_W'(in_x) + POS_W'(in_w) - POS_W'(1);
            y0_next        = POS_W'(in_y);
            y1_next        = POS_W'(in_y) + POS_W'(in_h) - POS_W'(1);
            empty_next     = (in_w == '0) || (in_h == '0);
            idx_next       = '0;
            col_start_next = '0;
            row_start_next = '0;
            found_next     = '0;
        end
        else if (searching)
        begin
            // Keep the first slot that holds each position.
            if (col_live && !found_reg[0] && in_slot(x0_reg, col_start_reg, cur_col_size))
            begin
                found_next[0] = 1'b1;
                c0_next       = idx_reg;
            end
            if (col_live && !found_reg[1] && in_slot(x1_reg, col_start_reg, cur_col_size))
            begin
                found_next[1] = 1'b1;
                c1_next       = idx_reg;
            end
            if (row_live && !found_reg[2] && in_slot(y0_reg, row_start_reg, cur_row_size))
            begin
                found_next[2] = 1'b1;
                r0_next       = idx_reg;
            end
            if (row_live && !found_reg[3] && in_slot(y1_reg, row_start_reg, cur_row_size))
            begin
                found_next[3] = 1'b1;
                r1_next       = idx_reg;
            end
            col_start_next = col_start_reg + cur_col_size;
            row_start_next = row_start_reg + cur_row_size;
            idx_next       = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg        <= x0_next;
        x1_reg        <= x1_next;
        y0_reg        <= y0_next;
        y1_reg        <= y1_next;
        empty_reg     <= empty_next;
        col_start_reg <= col_start_next;
        row_start_reg <= row_start_next;
        found_reg     <= found_next;
        c0_reg        <= c0_next;
        c1_reg        <= c1_next;
        r0_reg        <= r0_next;
        r1_reg        <= r1_next;
    end

    always_comb
    begin
        push_job.first_column = c0_reg;
        push_job.end_column   = c1_reg;
        push_job.first_row    = r0_reg;
        push_job.end_row      = r1_reg;
        push_job.num_columns  = ncols;
        push_job.err          = empty_reg || (found_reg != 4'b1111);
    end

endmodule

// File: hdl/tre_queue.sv
// Short job queue between the front end and the tile walker.
// Depends on tre_pkg for the job type and depth.
module tre_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tre_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output tre_pkg::job_t head_job
);
    import tre_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;

    assign full      = (count_reg == CNT_QW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_QW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_QW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hdl/tre_back.sv
// Tile walker: expands one job into tile numbers, column-major, into a
// registered output stage. Depends on tre_pkg.
module tre_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_valid,
    input  tre_pkg::job_t                  job,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tre_pkg::OUT_DATA_W-1:0] m_tdata,    // tile_number, zero pad
    output logic                           m_tlast,    // last_tile
    output logic                           m_tuser     // out_of_range
);
    import tre_pkg::*;

    logic             busy_reg, busy_next;
    job_t             job_reg, job_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic             out_valid_reg, out_valid_next;
    logic [TILE_W-1:0] tile_reg, tile_next;
    logic             last_reg, last_next;
    logic             oor_reg, oor_next;

    logic             can_load;
    logic             at_last;
    logic [2*IDX_W+1:0] tile_sum;

    assign can_load = !out_valid_reg || m_tready;
    assign pop      = !busy_reg && job_valid;
    assign at_last  = job_reg.err ||
                      ((col_reg == job_reg.end_column) && (row_reg == job_reg.end_row));
    assign tile_sum = (2*IDX_W+2)'(col_reg) +
                      (2*IDX_W+2)'(job_reg.num_columns) * (2*IDX_W+2)'(row_reg);

    always_comb
    begin
        busy_next      = busy_reg;
        job_next       = job_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        tile_next      = tile_reg;
        last_next      = last_reg;
        oor_next       = oor_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            job_next  = job;
            col_next  = job.first_column;
            row_next  = job.first_row;
        end
        if (busy_reg && can_load)
        begin
            out_valid_next = 1'b1;
            tile_next      = job_reg.err ? '0 : tile_sum[TILE_W-1:0];
            last_next      = at_last;
            oor_next       = job_reg.err;
            // Advance rows first, wrap to the next column at the end row.
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else if (row_reg == job_reg.end_row)
            begin
                row_next = job_reg.first_row;
                col_next = col_reg + IDX_W'(1);
            end
            else
            begin
                row_next = row_reg + IDX_W'(1);
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
        tile_reg <= tile_next;
        last_reg <= last_next;
        oor_reg  <= oor_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(tile_reg);
    assign m_tlast  = last_reg;
    assign m_tuser  = oor_reg;

endmodule

// File: hdl/tile_rectangle_enumerator.sv
// Tile rectangle enumerator: maps pixel rectangles to covered tile numbers.
// Instantiates tre_cfg, tre_front, tre_queue and tre_back; uses tre_pkg.
//
// Usage:
//   Write the tile counts and packed column/row sizes on the cfg channel
//   (index 0..5, always ready) while the block is idle. Send rectangles on
//   the s_ channel; tdata carries x, y, width, height, 16 bits each.
//   Each rectangle yields one or more results on the m_ channel: tdata
//   holds the tile number, tlast marks the final tile, tuser flags an
//   empty rectangle or one that leaves the layout (single result, tile 0).
// Timing:
//   The front end holds a rectangle through an accept state, a size search
//   over each of the max(MAX_COLUMNS, MAX_ROWS) slots, and an enqueue state
//   that waits while the queue is full. The walker then emits one tile per
//   cycle while the m_ channel takes each result.
// Reset and stalls:
//   Reset restores one column, one row and all sizes zero, and empties the
//   queue. A stalled m_ channel holds its result; the two-entry queue lets
//   the front end keep accepting until it fills.
module tile_rectangle_enumerator #(
    parameter int MAX_COLUMNS = tre_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tre_pkg::MAX_ROWS_DEF,
    parameter int SIZE_BITS   = tre_pkg::SIZE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tre_pkg::IN_DATA_W-1:0]    s_tdata,   // rect_x, rect_y, rect_width, rect_height
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tre_pkg::OUT_DATA_W-1:0]   m_tdata,   // tile_number, zero pad
    output logic                             m_tlast,   // last_tile
    output logic                             m_tuser,   // out_of_range
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tre_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tre_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tre_pkg::*;

    logic [SIZE_BITS-1:0] col_size [SLOT_MAX];
    logic [SIZE_BITS-1:0] row_size [SLOT_MAX];
    logic [CNT_W-1:0]     ncols, nrows;
    logic                 push, queue_full, pop, queue_not_empty;
    job_t                 push_job, head_job;

    tre_cfg #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .SIZE_BITS   (SIZE_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .col_size  (col_size),
        .row_size  (row_size),
        .ncols     (ncols),
        .nrows     (nrows)
    );

    tre_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .SIZE_BITS   (SIZE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .col_size   (col_size),
        .row_size   (row_size),
        .ncols      (ncols),
        .nrows      (nrows),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    tre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head_job  (head_job)
    );

    tre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_not_empty),
        .job       (head_job),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// File: hdl/tre_checker.sv
// Port-level checks for tile_rectangle_enumerator, bound to the top level.
// Depends on tre_pkg.
module tre_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tre_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tlast,
    input logic                           m_tuser
);
    import tre_pkg::*;

    // An error result stands alone and ends its rectangle.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("out-of-range result not marked last");

    // An error result carries tile zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[TILE_W-1:0] == '0))
        else $error("out-of-range result with nonzero tile");

    // The front end is busy searching right after a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted during slot search");

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind tile_rectangle_enumerator tre_checker u_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for tile_rectangle_enumerator: a directed step list, then random layouts.
// Predicts the tile transactions of unflagged rectangles from its own copy of the layout registers; needs tre_pkg.
module tb_top;
    import tre_pkg::*;

    localparam int SIZE_W          = SIZE_BITS_DEF;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int RANDOM_PHASES   = 9;
    localparam int RECTS_PER_PHASE = 50;

    typedef struct packed {
        logic [TILE_W-1:0] tile;
        logic              last;
        logic              err;
    } tile_result_t;

    localparam tile_result_t ERROR_RESULT = '{'0, 1'b1, 1'b1};

    typedef enum int {
        LAYOUT_SMALLEST,
        LAYOUT_LARGEST,
        LAYOUT_RAW,
        LAYOUT_MIXED
    } layout_style_t;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_CHOKED
    } ready_mode_t;

    typedef struct {
        bit                    is_write;
        cfg_index_t            reg_sel;
        logic [CFG_DATA_W-1:0] value;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [COORD_W-1:0]    w;
        logic [COORD_W-1:0]    h;
        bit                    flagged;
    } plan_step_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;    // rect_x, rect_y, rect_width, rect_height
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;    // tile_number, zero pad
    logic                   m_tlast;    // last_tile
    logic                   m_tuser;    // out_of_range
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Layout as the block should hold it
    logic [CNT_W-1:0]      cols_reg;
    logic [CNT_W-1:0]      rows_reg;
    logic [CFG_DATA_W-1:0] col_w_lo;
    logic [CFG_DATA_W-1:0] col_w_hi;
    logic [CFG_DATA_W-1:0] row_h_lo;
    logic [CFG_DATA_W-1:0] row_h_hi;

    tile_result_t tiles_due[$];
    tile_result_t head_tile;
    plan_step_t   plan[$];
    int unsigned  mismatches;
    int unsigned  burst_left;
    int unsigned  stalled_cycles;

    tile_rectangle_enumerator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [CFG_DATA_W-1:0] pack4(input logic [SIZE_W-1:0] a, b, c, d);
        return {d, c, b, a};
    endfunction

    function automatic int unsigned slot_size(input logic [CFG_DATA_W-1:0] lo, hi,
                                              input int unsigned i);
        logic [CFG_DATA_W-1:0] sizes;
        sizes = ((i < 4) ? lo : hi) >> (SIZE_W * (i % 4));
        return 32'(sizes[SIZE_W-1:0]);
    endfunction

    // Zero-width slots hold no pixel but still advance the slot number
    function automatic bit locate_slot(input int unsigned pos, input int unsigned count,
                                       input int unsigned limit,
                                       input logic [CFG_DATA_W-1:0] lo, hi,
                                       output int unsigned slot);
        int unsigned used;
        int unsigned start;
        int unsigned sz;
        slot  = 0;
        start = 0;
        used  = (count > limit) ? limit : count;
        for (int unsigned i = 0; i < used; i++)
        begin
            sz = slot_size(lo, hi, i);
            if (pos >= start && pos < start + sz)
            begin
                slot = i;
                return 1'b1;
            end
            start += sz;
        end
        return 1'b0;
    endfunction

    function automatic int unsigned layout_extent(input int unsigned count,
                                                  input int unsigned limit,
                                                  input logic [CFG_DATA_W-1:0] lo, hi);
        int unsigned used;
        int unsigned total;
        total = 0;
        used  = (count > limit) ? limit : count;
        for (int unsigned i = 0; i < used; i++)
            total += slot_size(lo, hi, i);
        return total;
    endfunction

    // Column-major walk over the covered tiles, or the single error transaction
    task automatic enumerate_tiles(input logic [COORD_W-1:0] x, y, w, h);
        int unsigned  c0, c1, r0, r1;
        int unsigned  far_x, far_y, used_cols;
        bit           fits;
        tile_result_t entry;
        c0 = 0;
        c1 = 0;
        r0 = 0;
        r1 = 0;
        far_x = 32'(x) + 32'(w) - 1;
        far_y = 32'(y) + 32'(h) - 1;
        fits = (w != 0) && (h != 0);
        if (fits)
            fits = locate_slot(32'(x), cols_reg, MAX_COLUMNS_DEF, col_w_lo, col_w_hi, c0);
        if (fits)
            fits = locate_slot(far_x, cols_reg, MAX_COLUMNS_DEF, col_w_lo, col_w_hi, c1);
        if (fits)
            fits = locate_slot(32'(y), rows_reg, MAX_ROWS_DEF, row_h_lo, row_h_hi, r0);
        if (fits)
            fits = locate_slot(far_y, rows_reg, MAX_ROWS_DEF, row_h_lo, row_h_hi, r1);
        if (!fits)
        begin
            tiles_due.push_back(ERROR_RESULT);
            return;
        end
        used_cols = (cols_reg > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : cols_reg;
        for (int unsigned c = c0; c <= c1; c++)
        begin
            for (int unsigned r = r0; r <= r1; r++)
            begin
                entry.tile = TILE_W'(c + used_cols * r);
                entry.last = (c == c1 && r == r1);
                entry.err  = 1'b0;
                tiles_due.push_back(entry);
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (tiles_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t sel, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = sel;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (sel)
            REG_NUM_COLUMNS:        cols_reg = value[CNT_W-1:0];
            REG_NUM_ROWS:           rows_reg = value[CNT_W-1:0];
            REG_COLUMN_WIDTHS_LOW:  col_w_lo = value;
            REG_COLUMN_WIDTHS_HIGH: col_w_hi = value;
            REG_ROW_HEIGHTS_LOW:    row_h_lo = value;
            REG_ROW_HEIGHTS_HIGH:   row_h_hi = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Flagged rectangles carry the error transaction typed in; the rest are predicted
    task automatic send_rect(input logic [COORD_W-1:0] x, y, w, h, input bit flagged);
        int unsigned gap;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {h, w, y, x};
        do
            @(posedge clk);
        while (!s_tready);
        if (flagged)
            tiles_due.push_back(ERROR_RESULT);
        else
            enumerate_tiles(x, y, w, h);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(8, 1);
            gap = ($urandom_range(3, 0) == 0) ? $urandom_range(30, 8) : $urandom_range(4, 1);
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        else
            burst_left--;
    endtask

    task automatic add_write(input cfg_index_t sel, input logic [CFG_DATA_W-1:0] value);
        plan_step_t step;
        step          = '{reg_sel: sel, default: '0};
        step.is_write = 1'b1;
        step.value    = value;
        plan.push_back(step);
    endtask

    task automatic add_rect(input logic [COORD_W-1:0] x, y, w, h, input bit flagged);
        plan_step_t step;
        step         = '{reg_sel: REG_NUM_COLUMNS, default: '0};
        step.x       = x;
        step.y       = y;
        step.w       = w;
        step.h       = h;
        step.flagged = flagged;
        plan.push_back(step);
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return CNT_W'($urandom_range(15, 9));
            default: return CNT_W'($urandom_range(8, 1));
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size(input layout_style_t style);
        if (style == LAYOUT_LARGEST)
            return '1;
        if (style == LAYOUT_SMALLEST)
            return SIZE_W'($urandom_range(40, 1));
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return SIZE_W'($urandom_range(16383, 1000));
            default: return SIZE_W'($urandom_range(40, 1));
        endcase
    endfunction

    task automatic load_random_layout(input layout_style_t style);
        logic [CNT_W-1:0]      cols, rows;
        logic [SIZE_W-1:0]     sizes [16];
        logic [CFG_DATA_W-1:0] fill;
        for (int i = 0; i < 16; i++)
            sizes[i] = pick_size(style);
        case (style)
            LAYOUT_SMALLEST:
            begin
                cols = CNT_W'(1);
                rows = CNT_W'(1);
            end
            LAYOUT_LARGEST:
            begin
                cols = CNT_W'(MAX_COLUMNS_DEF);
                rows = CNT_W'(MAX_ROWS_DEF);
            end
            default:
            begin
                cols = pick_count();
                rows = pick_count();
            end
        endcase
        wait_idle();
        // upper bits of the count registers are don't-care; fill them with noise
        fill = CFG_DATA_W'({$urandom, $urandom});
        write_reg(REG_NUM_COLUMNS, {fill[CFG_DATA_W-1:CNT_W], cols});
        fill = CFG_DATA_W'({$urandom, $urandom});
        write_reg(REG_NUM_ROWS, {fill[CFG_DATA_W-1:CNT_W], rows});
        if (style == LAYOUT_RAW)
        begin
            write_reg(REG_COLUMN_WIDTHS_LOW,  CFG_DATA_W'({$urandom, $urandom}));
            write_reg(REG_COLUMN_WIDTHS_HIGH, CFG_DATA_W'({$urandom, $urandom}));
            write_reg(REG_ROW_HEIGHTS_LOW,    CFG_DATA_W'({$urandom, $urandom}));
            write_reg(REG_ROW_HEIGHTS_HIGH,   CFG_DATA_W'({$urandom, $urandom}));
        end
        else
        begin
            write_reg(REG_COLUMN_WIDTHS_LOW,  pack4(sizes[0], sizes[1], sizes[2], sizes[3]));
            write_reg(REG_COLUMN_WIDTHS_HIGH, pack4(sizes[4], sizes[5], sizes[6], sizes[7]));
            write_reg(REG_ROW_HEIGHTS_LOW,    pack4(sizes[8], sizes[9], sizes[10], sizes[11]));
            write_reg(REG_ROW_HEIGHTS_HIGH,
                      pack4(sizes[12], sizes[13], sizes[14], sizes[15]));
        end
    endtask

    // Start inside the layout; span mostly short, sometimes long, now and then one past the edge
    function automatic void pick_extent(input int unsigned extent,
                                        output logic [COORD_W-1:0] start,
                                        output logic [COORD_W-1:0] span);
        int unsigned reach;
        int unsigned room;
        reach = (extent > 65536) ? 65536 : extent;
        start = COORD_W'($urandom_range(reach - 1, 0));
        room  = extent - start;
        if (room > 65535)
            room = 65535;
        case ($urandom_range(19, 0))
            0:             span = COORD_W'((room == 65535) ? room : room + 1);
            1, 2, 3, 4, 5: span = COORD_W'($urandom_range(room, 1));
            default:       span = COORD_W'($urandom_range((room < 48) ? room : 48, 1));
        endcase
    endfunction

    task automatic send_random_rects(input int unsigned count);
        int unsigned        span_w, span_h;
        logic [COORD_W-1:0] x, y, w, h;
        span_w = layout_extent(cols_reg, MAX_COLUMNS_DEF, col_w_lo, col_w_hi);
        span_h = layout_extent(rows_reg, MAX_ROWS_DEF, row_h_lo, row_h_hi);
        repeat (count)
        begin
            if (span_w == 0 || span_h == 0 || $urandom_range(6, 0) == 0)
            begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
                w = COORD_W'($urandom);
                h = COORD_W'($urandom);
                case ($urandom_range(3, 0))
                    0:       w = '0;
                    1:       h = '0;
                    default: ;
                endcase
            end
            else
            begin
                pick_extent(span_w, x, w);
                pick_extent(span_h, y, h);
            end
            send_rect(x, y, w, h, 1'b0);
        end
    endtask

    function automatic void note_mismatch(input string field, input int unsigned want,
                                          input int unsigned got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tiles_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: tile transaction with none pending, expected nothing, actual %0d",
                         $time, m_tdata);
            end
            else
            begin
                head_tile = tiles_due.pop_front();
                if (m_tdata !== OUT_DATA_W'(head_tile.tile))
                    note_mismatch("tdata", head_tile.tile, m_tdata);
                if (m_tlast !== head_tile.last)
                    note_mismatch("tlast", head_tile.last, m_tlast);
                if (m_tuser !== head_tile.err)
                    note_mismatch("tuser", head_tile.err, m_tuser);
            end
        end
    end

    // Count cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stalled_cycles <= 0;
        else if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial
    begin : receiver
        int unsigned stretch;
        ready_mode_t mode;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stretch = $urandom_range(200, 20);
            mode    = ready_mode_t'($urandom_range(2, 0));
            for (int unsigned k = 0; k < stretch; k++)
            begin
                @(negedge clk);
                case (mode)
                    READY_ALWAYS: m_tready = 1'b1;
                    READY_COIN:   m_tready = 1'($urandom_range(1, 0));
                    // hold ready low, then raise it, in a repeating pattern
                    default:      m_tready = (k % 24) >= 20;
                endcase
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_NUM_COLUMNS;
        cfg_data       = '0;
        cols_reg       = CNT_W'(1);
        rows_reg       = CNT_W'(1);
        col_w_lo       = '0;
        col_w_hi       = '0;
        row_h_lo       = '0;
        row_h_hi       = '0;
        mismatches     = 0;
        burst_left     = 0;
        stalled_cycles = 0;

        // Reset layout has only zero sizes: nothing fits
        add_rect(16'd0, 16'd0, 16'd1, 16'd1, 1'b1);
        add_rect(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);

        // Three columns with an empty middle one, two rows with a maximal second one
        add_write(REG_NUM_COLUMNS, CFG_DATA_W'(3));
        add_write(REG_NUM_ROWS, CFG_DATA_W'(2));
        add_write(REG_COLUMN_WIDTHS_LOW, pack4(14'd100, 14'd0, 14'd50, 14'd0));
        add_write(REG_COLUMN_WIDTHS_HIGH, '1);
        add_write(REG_ROW_HEIGHTS_LOW, pack4(14'd10, 14'd16383, 14'd0, 14'd0));
        add_write(REG_ROW_HEIGHTS_HIGH, pack4(14'd7, 14'd7, 14'd7, 14'd7));
        add_rect(16'd0, 16'd0, 16'd1, 16'd1, 1'b0);
        add_rect(16'd0, 16'd0, 16'd150, 16'd16393, 1'b0);
        add_rect(16'd99, 16'd9, 16'd2, 16'd2, 1'b0);
        add_rect(16'd149, 16'd16392, 16'd1, 16'd1, 1'b0);
        add_rect(16'd150, 16'd0, 16'd1, 16'd1, 1'b1);
        add_rect(16'd0, 16'd16393, 16'd1, 16'd1, 1'b1);
        add_rect(16'd0, 16'd0, 16'd0, 16'd5, 1'b1);
        add_rect(16'd0, 16'd0, 16'd5, 16'd0, 1'b1);
        add_rect(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        add_rect(16'd0, 16'd0, 16'hFFFF, 16'd1, 1'b1);

        // Column count above the maximum clamps to eight; full 8x8 grid
        add_write(REG_NUM_COLUMNS, CFG_DATA_W'(15));
        add_write(REG_NUM_ROWS, CFG_DATA_W'(8));
        add_write(REG_COLUMN_WIDTHS_LOW, pack4(14'd1, 14'd1, 14'd1, 14'd1));
        add_write(REG_COLUMN_WIDTHS_HIGH, pack4(14'd1, 14'd1, 14'd1, 14'd16383));
        add_write(REG_ROW_HEIGHTS_LOW, pack4(14'd1, 14'd1, 14'd1, 14'd1));
        add_write(REG_ROW_HEIGHTS_HIGH, pack4(14'd1, 14'd1, 14'd1, 14'd1));
        add_rect(16'd0, 16'd0, 16'd16390, 16'd8, 1'b0);
        add_rect(16'd7, 16'd7, 16'd1, 16'd1, 1'b0);
        add_rect(16'd16389, 16'd0, 16'd1, 16'd1, 1'b0);
        add_rect(16'd16390, 16'd0, 16'd1, 16'd1, 1'b1);
        add_rect(16'd0, 16'd8, 16'd1, 16'd1, 1'b1);

        // Zero counts leave no column or no row
        add_write(REG_NUM_COLUMNS, CFG_DATA_W'(0));
        add_rect(16'd0, 16'd0, 16'd1, 16'd1, 1'b1);
        add_write(REG_NUM_COLUMNS, CFG_DATA_W'(8));
        add_write(REG_NUM_ROWS, CFG_DATA_W'(0));
        add_rect(16'd0, 16'd0, 16'd1, 16'd1, 1'b1);

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                wait_idle();
                write_reg(plan[i].reg_sel, plan[i].value);
            end
            else
                send_rect(plan[i].x, plan[i].y, plan[i].w, plan[i].h, plan[i].flagged);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       load_random_layout(LAYOUT_SMALLEST);
                1:       load_random_layout(LAYOUT_LARGEST);
                2:       load_random_layout(LAYOUT_RAW);
                default: load_random_layout(LAYOUT_MIXED);
            endcase
            send_random_rects(RECTS_PER_PHASE);
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && tiles_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
